// ----- src/assert_macros.svh -----
// Assertion macros used by the edge magnitude RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/mdem_pkg.sv -----
// Package with widths, constants, types and arithmetic helpers of the edge core.
`timescale 1ns / 1ps

package mdem_pkg;

  localparam int MaxWidth  = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int WidthRegW = 11;
  localparam int HeightW   = 16;
  localparam int PixW      = 8;
  localparam int PrewW     = 12;
  localparam int SobW      = 12;
  localparam int KirW      = 14;
  localparam int FifoDepth = 8;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [WidthRegW-1:0] WidthReset  = 11'd640;
  localparam logic [HeightW-1:0]   HeightReset = 16'd480;

  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  typedef logic [PixW-1:0] pix_t;

  // Neighbors of the 3x3 window, row then column; center omitted.
  typedef struct packed {
    pix_t p00, p01, p02;
    pix_t p10, p12;
    pix_t p20, p21, p22;
  } window_t;

  typedef struct packed {
    logic signed [10:0] prew0, prew1, prew2, prew3;
    logic signed [10:0] sob0, sob1, sob2, sob3;
    logic signed [12:0] kir0, kir1, kir2, kir3;
  } resp_t;

  typedef struct packed {
    logic             frame_end;
    logic [KirW-1:0]  kirsch;
    logic [SobW-1:0]  sobel;
    logic [PrewW-1:0] prewitt;
  } result_t;

  function automatic logic signed [10:0] diff10(input logic [9:0] a, input logic [9:0] b);
    diff10 = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // 5*pos - 3*(total - pos) = 8*pos - 3*total
  function automatic logic signed [12:0] kirsch_resp(input logic [9:0] pos,
                                                     input logic [10:0] tot);
    logic [13:0] pos8;
    logic [13:0] tot3;
    logic [13:0] dif;
    pos8 = {1'b0, pos, 3'b000};
    tot3 = {2'b00, tot, 1'b0} + {3'b000, tot};
    dif  = pos8 - tot3;
    kirsch_resp = $signed(dif[12:0]);
  endfunction

  function automatic logic [9:0] abs11(input logic signed [10:0] v);
    logic [10:0] m;
    m = v[10] ? 11'(-v) : 11'(v);
    abs11 = m[9:0];
  endfunction

  function automatic logic [11:0] abs13(input logic signed [12:0] v);
    logic [12:0] m;
    m = v[12] ? 13'(-v) : 13'(v);
    abs13 = m[11:0];
  endfunction

endpackage

// ----- src/multi_direction_edge_magnitude_core.sv -----
// Top level: four-direction Prewitt, Sobel and Kirsch edge magnitude on a pixel stream.
//
// Pixels enter on the s_axis channel in raster order, one per transaction.
// For every interior pixel one result transaction leaves on m_axis carrying
// the three unsigned magnitudes; tlast marks the frame's last result. Border
// pixels are absorbed and produce nothing.
// image_width (0x0) and image_height (0x4) are set over the APB port while
// the core is idle; reset loads 640 x 480 and starts at row 0, column 0.
// Throughput is one pixel per clock while s_axis_tready is high. A result
// passes line store read, window capture, kernel responses and the sum into
// the output queue. The two previous rows live in one 1024 x 16 synchronous
// RAM that is read on accept and written back the next cycle; neighboring
// accesses never hit the same entry since a row has at least 3 pixels.
// An 8-entry output queue absorbs a stalled receiver; s_axis_tready drops
// when pipeline plus queue hold 8 transactions, so nothing is lost.
// The RAM has no reset; the window column registers and counters clear at reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_direction_edge_magnitude_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [11:0] prewitt, [23:12] sobel, [37:24] kirsch, pad
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration
  logic [mdem_pkg::WidthRegW-1:0] width_q;
  logic [mdem_pkg::HeightW-1:0]   height_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mdem_pkg::WidthReset;
      height_q <= mdem_pkg::HeightReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mdem_pkg::RegImageWidth:  width_q  <= pwdata[mdem_pkg::WidthRegW-1:0];
        mdem_pkg::RegImageHeight: height_q <= pwdata[mdem_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mdem_pkg::RegImageWidth:  prdata = 32'(width_q);
      mdem_pkg::RegImageHeight: prdata = 32'(height_q);
      default:                  prdata = '0;
    endcase
  end

  // Position tracking
  logic [mdem_pkg::WidthRegW-1:0] eff_w;
  logic [mdem_pkg::HeightW-1:0]   eff_h;
  logic [mdem_pkg::ColW-1:0]      col_q, col_d;
  logic [mdem_pkg::HeightW-1:0]   row_q, row_d;
  logic                           last_col, last_row, in_acc;

  always_comb begin
    if (width_q < mdem_pkg::WidthRegW'(3)) begin
      eff_w = mdem_pkg::WidthRegW'(3);
    end else if (width_q > mdem_pkg::WidthRegW'(mdem_pkg::MaxWidth)) begin
      eff_w = mdem_pkg::WidthRegW'(mdem_pkg::MaxWidth);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < mdem_pkg::HeightW'(3)) ? mdem_pkg::HeightW'(3) : height_q;
  end

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign last_col = mdem_pkg::WidthRegW'(col_q) >= (eff_w - mdem_pkg::WidthRegW'(1));
  assign last_row = row_q >= (eff_h - mdem_pkg::HeightW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + mdem_pkg::HeightW'(1);
      end else begin
        col_d = col_q + mdem_pkg::ColW'(1);
      end
    end
  end

  // Stage 1: line store read, write-back and window shift
  logic [2*mdem_pkg::PixW-1:0] line_mem [mdem_pkg::MaxWidth];
  logic [2*mdem_pkg::PixW-1:0] line_rd_q;
  logic                        s1_valid_q, s1_emit_q, s1_last_q;
  logic [mdem_pkg::ColW-1:0]   s1_addr_q;
  mdem_pkg::pix_t              s1_pix_q;
  mdem_pkg::pix_t              line_top, line_mid;
  mdem_pkg::pix_t              wcol_q [6];

  assign line_top = line_rd_q[mdem_pkg::PixW-1:0];
  assign line_mid = line_rd_q[2*mdem_pkg::PixW-1:mdem_pkg::PixW];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_rd_q <= line_mem[col_q];
    end
    if (s1_valid_q) begin
      line_mem[s1_addr_q] <= {s1_pix_q, line_mid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= in_acc;
      if (in_acc) begin
        s1_emit_q <= (row_q >= mdem_pkg::HeightW'(2)) && (col_q >= mdem_pkg::ColW'(2));
        s1_last_q <= last_col & last_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= col_q;
      s1_pix_q  <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        wcol_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      wcol_q[0] <= wcol_q[3];
      wcol_q[1] <= wcol_q[4];
      wcol_q[2] <= wcol_q[5];
      wcol_q[3] <= line_top;
      wcol_q[4] <= line_mid;
      wcol_q[5] <= s1_pix_q;
    end
  end

  // Stage 2: window capture
  logic              s2_valid_q, s2_emit_q, s2_last_q;
  mdem_pkg::window_t s2_win_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_win_q.p00 <= wcol_q[0];
      s2_win_q.p10 <= wcol_q[1];
      s2_win_q.p20 <= wcol_q[2];
      s2_win_q.p01 <= wcol_q[3];
      s2_win_q.p21 <= wcol_q[5];
      s2_win_q.p02 <= line_top;
      s2_win_q.p12 <= line_mid;
      s2_win_q.p22 <= s1_pix_q;
      s2_emit_q    <= s1_emit_q;
      s2_last_q    <= s1_last_q;
    end
  end

  // Stage 3: directional responses
  logic              s3_valid_q, s3_emit_q, s3_last_q;
  mdem_pkg::resp_t   s3_resp_q, resp_d;
  logic [9:0]        c0, c2, r0, r2, d45p, d45n, d135p, d135n;
  logic [9:0]        sc0, sc2, sr0, sr2, sd45p, sd45n, sd135p, sd135n;
  logic [10:0]       tot;

  always_comb begin
    c0     = 10'(s2_win_q.p00) + 10'(s2_win_q.p10) + 10'(s2_win_q.p20);
    c2     = 10'(s2_win_q.p02) + 10'(s2_win_q.p12) + 10'(s2_win_q.p22);
    r0     = 10'(s2_win_q.p00) + 10'(s2_win_q.p01) + 10'(s2_win_q.p02);
    r2     = 10'(s2_win_q.p20) + 10'(s2_win_q.p21) + 10'(s2_win_q.p22);
    d45p   = 10'(s2_win_q.p01) + 10'(s2_win_q.p02) + 10'(s2_win_q.p12);
    d45n   = 10'(s2_win_q.p10) + 10'(s2_win_q.p20) + 10'(s2_win_q.p21);
    d135p  = 10'(s2_win_q.p00) + 10'(s2_win_q.p01) + 10'(s2_win_q.p10);
    d135n  = 10'(s2_win_q.p12) + 10'(s2_win_q.p21) + 10'(s2_win_q.p22);
    sc0    = 10'(s2_win_q.p00) + {1'b0, s2_win_q.p10, 1'b0} + 10'(s2_win_q.p20);
    sc2    = 10'(s2_win_q.p02) + {1'b0, s2_win_q.p12, 1'b0} + 10'(s2_win_q.p22);
    sr0    = 10'(s2_win_q.p00) + {1'b0, s2_win_q.p01, 1'b0} + 10'(s2_win_q.p02);
    sr2    = 10'(s2_win_q.p20) + {1'b0, s2_win_q.p21, 1'b0} + 10'(s2_win_q.p22);
    sd45p  = 10'(s2_win_q.p01) + {1'b0, s2_win_q.p02, 1'b0} + 10'(s2_win_q.p12);
    sd45n  = 10'(s2_win_q.p10) + {1'b0, s2_win_q.p20, 1'b0} + 10'(s2_win_q.p21);
    sd135p = {1'b0, s2_win_q.p00, 1'b0} + 10'(s2_win_q.p01) + 10'(s2_win_q.p10);
    sd135n = 10'(s2_win_q.p12) + 10'(s2_win_q.p21) + {1'b0, s2_win_q.p22, 1'b0};
    tot    = 11'(c0) + 11'(c2) + 11'(s2_win_q.p01) + 11'(s2_win_q.p21);

    resp_d.prew0 = mdem_pkg::diff10(c2, c0);
    resp_d.prew1 = mdem_pkg::diff10(r2, r0);
    resp_d.prew2 = mdem_pkg::diff10(d45p, d45n);
    resp_d.prew3 = mdem_pkg::diff10(d135p, d135n);
    resp_d.sob0  = mdem_pkg::diff10(sc2, sc0);
    resp_d.sob1  = mdem_pkg::diff10(sr2, sr0);
    resp_d.sob2  = mdem_pkg::diff10(sd45p, sd45n);
    resp_d.sob3  = mdem_pkg::diff10(sd135p, sd135n);
    resp_d.kir0  = mdem_pkg::kirsch_resp(c2, tot);
    resp_d.kir1  = mdem_pkg::kirsch_resp(d45n, tot);
    resp_d.kir2  = mdem_pkg::kirsch_resp(d45p, tot);
    resp_d.kir3  = mdem_pkg::kirsch_resp(d135p, tot);
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_resp_q <= resp_d;
      s3_emit_q <= s2_emit_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Stage 4: magnitudes into the output queue
  mdem_pkg::result_t              res_d;
  mdem_pkg::result_t              fifo_q [mdem_pkg::FifoDepth];
  logic [mdem_pkg::FifoAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [mdem_pkg::FifoCntW-1:0]  cnt_q;
  logic [mdem_pkg::FifoCntW+1:0]  occ;
  logic                           push, pop;

  always_comb begin
    res_d.prewitt = 12'(mdem_pkg::abs11(s3_resp_q.prew0)) + 12'(mdem_pkg::abs11(s3_resp_q.prew1))
                  + 12'(mdem_pkg::abs11(s3_resp_q.prew2)) + 12'(mdem_pkg::abs11(s3_resp_q.prew3));
    res_d.sobel   = 12'(mdem_pkg::abs11(s3_resp_q.sob0)) + 12'(mdem_pkg::abs11(s3_resp_q.sob1))
                  + 12'(mdem_pkg::abs11(s3_resp_q.sob2)) + 12'(mdem_pkg::abs11(s3_resp_q.sob3));
    res_d.kirsch  = 14'(mdem_pkg::abs13(s3_resp_q.kir0)) + 14'(mdem_pkg::abs13(s3_resp_q.kir1))
                  + 14'(mdem_pkg::abs13(s3_resp_q.kir2)) + 14'(mdem_pkg::abs13(s3_resp_q.kir3));
    res_d.frame_end = s3_last_q;
  end

  assign push = s3_valid_q & s3_emit_q;
  assign pop  = m_axis_tvalid & m_axis_tready;
  assign occ  = (mdem_pkg::FifoCntW+2)'(cnt_q) + (mdem_pkg::FifoCntW+2)'(s1_valid_q)
              + (mdem_pkg::FifoCntW+2)'(s2_valid_q) + (mdem_pkg::FifoCntW+2)'(s3_valid_q);
  assign s_axis_tready = occ < (mdem_pkg::FifoCntW+2)'(mdem_pkg::FifoDepth);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + mdem_pkg::FifoAw'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + mdem_pkg::FifoAw'(1);
      end
      cnt_q <= cnt_q + mdem_pkg::FifoCntW'(push) - mdem_pkg::FifoCntW'(pop);
    end
  end

  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {2'b00, fifo_q[rd_ptr_q].kirsch, fifo_q[rd_ptr_q].sobel,
                          fifo_q[rd_ptr_q].prewitt};
  assign m_axis_tlast  = fifo_q[rd_ptr_q].frame_end;

  `ASSERT_IMPLY(a_no_overflow, clk_i, rst_ni, push, cnt_q < mdem_pkg::FifoCntW'(mdem_pkg::FifoDepth))
  `ASSERT_IMPLY(a_occ_bound, clk_i, rst_ni, 1'b1, occ <= (mdem_pkg::FifoCntW+2)'(mdem_pkg::FifoDepth))
  `ASSERT_NEXT(a_accept_s1, clk_i, rst_ni, in_acc, s1_valid_q)

endmodule
